FILE: rtl/dlfs_pkg.sv
// Package for the data link frame stuffer: item and command types,
// sequencer steps, register indexes and reset values. No dependencies.
package dlfs_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] STUFF_MASK = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_FLAG     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ZERO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_ONE  = 3'd4;

    localparam logic [BYTE_W-1:0] RST_FLAG      = 8'd126;
    localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd125;
    localparam logic [BYTE_W-1:0] RST_ADDRESS   = 8'd3;
    localparam logic [BYTE_W-1:0] RST_CTRL_ZERO = 8'd0;
    localparam logic [BYTE_W-1:0] RST_CTRL_ONE  = 8'd64;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] control_seq_zero;
        logic [BYTE_W-1:0] control_seq_one;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] bcc2;
        logic              first;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic push;
        logic full;
    } t_push_ctl;

    typedef struct packed {
        logic pop;
        logic valid;
    } t_pop_ctl;

    typedef enum logic [2:0] {
        ST_BEGIN,
        ST_FLAG,
        ST_ADDR,
        ST_CTRL,
        ST_BCC1,
        ST_DATA,
        ST_BCC2,
        ST_CLOSE
    } t_step;

endpackage

FILE: rtl/dlfs_front.sv
// Front end of the frame stuffer: accepts input items, keeps the running
// payload parity and builds one command per item. Uses dlfs_pkg.
module dlfs_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dlfs_pkg::t_cfg           i_cfg,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [dlfs_pkg::BYTE_W-1:0] i_data,
    input  logic                     i_first,
    input  logic                     i_last,
    input  logic                     i_seq,
    input  logic                     i_full,
    output logic                     o_push,
    output dlfs_pkg::t_cmd           o_cmd
);
    import dlfs_pkg::*;

    logic [BYTE_W-1:0] r_parity;
    logic [BYTE_W-1:0] n_parity;
    logic [BYTE_W-1:0] w_sum;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign w_sum   = (i_first ? '0 : r_parity) ^ i_data;

    always_comb begin
        o_cmd.data  = i_data;
        o_cmd.ctrl  = i_seq ? i_cfg.control_seq_one : i_cfg.control_seq_zero;
        o_cmd.bcc2  = w_sum;
        o_cmd.first = i_first;
        o_cmd.last  = i_last;
        n_parity    = r_parity;
        if (o_push) begin
            n_parity = i_last ? '0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity <= '0;
        end else begin
            r_parity <= n_parity;
        end
    end

endmodule

FILE: rtl/dlfs_queue.sv
// Short command queue between front and back of the frame stuffer.
// Flip-flop storage, QUEUE_DEPTH entries. Uses dlfs_pkg.
module dlfs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  dlfs_pkg::t_cmd      i_cmd,
    output dlfs_pkg::t_push_ctl o_push_ctl,
    input  logic                i_pop,
    output dlfs_pkg::t_pop_ctl  o_pop_ctl,
    output dlfs_pkg::t_cmd      o_head
);
    import dlfs_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_full;
    logic              w_empty;
    logic              w_push;
    logic              w_pop;

    assign w_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);
    assign w_push  = i_push && !w_full;
    assign w_pop   = i_pop && !w_empty;

    assign o_push_ctl.push = w_push;
    assign o_push_ctl.full = w_full;
    assign o_pop_ctl.pop   = w_pop;
    assign o_pop_ctl.valid = !w_empty;
    assign o_head          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/dlfs_back.sv
// Back end of the frame stuffer: walks the header, data and trailer steps
// of the head command, stuffs bytes and drives the output register.
// Uses dlfs_pkg.
module dlfs_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dlfs_pkg::t_cfg              i_cfg,
    input  dlfs_pkg::t_pop_ctl          i_pop_ctl,
    input  dlfs_pkg::t_cmd              i_head,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [dlfs_pkg::BYTE_W-1:0] o_data,
    output logic                        o_frame_end,
    output logic                        o_run_end
);
    import dlfs_pkg::*;

    t_step             r_step;
    t_step             n_step;
    t_step             w_step;
    logic              r_esc;
    logic              n_esc;
    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_frame_end;
    logic              r_run_end;
    logic              w_load;
    logic              w_stuffable;
    logic              w_need_esc;
    logic              w_last_step;
    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] w_out_byte;

    assign w_load = i_pop_ctl.valid && (!r_valid || i_ready);

    always_comb begin
        w_step = r_step;
        if (r_step == ST_BEGIN) begin
            w_step = i_head.first ? ST_FLAG : ST_DATA;
        end
    end

    always_comb begin
        w_byte      = i_head.data;
        w_stuffable = 1'b1;
        w_last_step = 1'b0;
        n_step      = r_step;
        unique case (w_step)
            ST_FLAG: begin
                w_byte      = i_cfg.flag_byte;
                w_stuffable = 1'b0;
                n_step      = ST_ADDR;
            end
            ST_ADDR: begin
                w_byte = i_cfg.address_byte;
                n_step = ST_CTRL;
            end
            ST_CTRL: begin
                w_byte = i_head.ctrl;
                n_step = ST_BCC1;
            end
            ST_BCC1: begin
                w_byte = i_cfg.address_byte ^ i_head.ctrl;
                n_step = ST_DATA;
            end
            ST_DATA: begin
                w_byte      = i_head.data;
                w_last_step = !i_head.last;
                n_step      = i_head.last ? ST_BCC2 : ST_BEGIN;
            end
            ST_BCC2: begin
                w_byte = i_head.bcc2;
                n_step = ST_CLOSE;
            end
            ST_CLOSE: begin
                w_byte      = i_cfg.flag_byte;
                w_stuffable = 1'b0;
                w_last_step = 1'b1;
                n_step      = ST_BEGIN;
            end
            default: begin
                n_step = ST_BEGIN;
            end
        endcase

        w_need_esc = w_stuffable && !r_esc &&
                     ((w_byte == i_cfg.flag_byte) || (w_byte == i_cfg.escape_byte));
        w_out_byte = w_need_esc ? i_cfg.escape_byte :
                     (r_esc ? (w_byte ^ STUFF_MASK) : w_byte);

        n_esc = r_esc;
        if (!w_load) begin
            n_step = r_step;
        end else if (w_need_esc) begin
            n_step = w_step;
            n_esc  = 1'b1;
        end else begin
            n_esc = 1'b0;
        end
    end

    assign o_pop = w_load && !w_need_esc && w_last_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_BEGIN;
            r_esc  <= 1'b0;
        end else begin
            r_step <= n_step;
            r_esc  <= n_esc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_data      <= w_out_byte;
            r_frame_end <= (w_step == ST_CLOSE);
            r_run_end   <= !w_need_esc && w_last_step;
        end
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_frame_end = r_frame_end;
    assign o_run_end   = r_run_end;

endmodule

FILE: rtl/data_link_frame_stuffer_unit.sv
// Top level of the data link frame stuffer: register file, front end,
// command queue and back end. Uses dlfs_pkg, dlfs_front, dlfs_queue, dlfs_back.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata payload, tlast last, tuser first/seq
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata line byte, tlast frame end, tuser run end
//  cfg       in         i_cfg_we                      i_cfg_idx, i_cfg_wdata
//
// One line byte leaves per cycle while m_axis is not stalled; the bytes of an item are set by
// the back-end step sequencer (header, stuffed data, trailer).
// Items are taken in the cycle they arrive while the 4-entry queue has room.
// Reset clears the queue, the parity and the sequencer, and loads register defaults.
// A stall on m_axis holds the output register; the queue keeps absorbing items while it has room.
module data_link_frame_stuffer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,  // [7:0] payload_byte
    input  logic                           s_axis_tlast,  // last_of_frame
    input  logic [1:0]                     s_axis_tuser,  // [0] first_of_frame, [1] sequence_bit
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,  // [7:0] line_byte
    output logic                           m_axis_tlast,  // frame_end
    output logic [0:0]                     m_axis_tuser,  // [0] run_end
    input  logic                           i_cfg_we,
    input  logic [dlfs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dlfs_pkg::BYTE_W-1:0]    i_cfg_wdata
);
    import dlfs_pkg::*;

    t_cfg      r_cfg;
    t_cmd      w_cmd;
    t_cmd      w_head;
    t_push_ctl w_push_ctl;
    t_pop_ctl  w_pop_ctl;
    logic      w_push;
    logic      w_pop;
    logic      w_run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte        <= RST_FLAG;
            r_cfg.escape_byte      <= RST_ESCAPE;
            r_cfg.address_byte     <= RST_ADDRESS;
            r_cfg.control_seq_zero <= RST_CTRL_ZERO;
            r_cfg.control_seq_one  <= RST_CTRL_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FLAG:      r_cfg.flag_byte        <= i_cfg_wdata;
                CFG_ESCAPE:    r_cfg.escape_byte      <= i_cfg_wdata;
                CFG_ADDRESS:   r_cfg.address_byte     <= i_cfg_wdata;
                CFG_CTRL_ZERO: r_cfg.control_seq_zero <= i_cfg_wdata;
                CFG_CTRL_ONE:  r_cfg.control_seq_one  <= i_cfg_wdata;
                default:       r_cfg                  <= r_cfg;
            endcase
        end
    end

    dlfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_first (s_axis_tuser[0]),
        .i_last  (s_axis_tlast),
        .i_seq   (s_axis_tuser[1]),
        .i_full  (w_push_ctl.full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    dlfs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_cmd),
        .o_push_ctl (w_push_ctl),
        .i_pop      (w_pop),
        .o_pop_ctl  (w_pop_ctl),
        .o_head     (w_head)
    );

    dlfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_pop_ctl   (w_pop_ctl),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_frame_end (m_axis_tlast),
        .o_run_end   (w_run_end)
    );

    assign m_axis_tuser[0] = w_run_end;

endmodule

FILE: rtl/dlfs_checker.sv
// Port-level checker for data_link_frame_stuffer_unit and its bind.
// Sees the top-level stream ports only. No dependencies.
module dlfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic [1:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [0:0] m_axis_tuser
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata)
            && $stable(s_axis_tlast) && $stable(s_axis_tuser))
        else $error("input item changed while held off");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_close_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[0])
        else $error("closing flag is not the last item of its run");

    a_accept_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted item produced no output in time");

    a_full_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> m_axis_tvalid)
        else $error("input held off with no output pending");

endmodule

bind data_link_frame_stuffer_unit dlfs_checker u_dlfs_checker (.*);
